// ===== sv/block_bump_allocator_assert.svh =====
// Assertion macros used by the block bump allocator sequencer.
`ifndef BLOCK_BUMP_ALLOCATOR_ASSERT_SVH
`define BLOCK_BUMP_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBA_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BBA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/bba_pkg.sv =====
// Types, constants and codes shared by the block bump allocator.
package bba_pkg;

	localparam int BLOCK_BYTES = 4096;
	localparam int BLOCK_LIMIT = 64;
	localparam int MAX_BLOCKS  = 64;

	localparam int BLK_W    = $clog2(MAX_BLOCKS);
	localparam int CNT_W    = $clog2(BLOCK_LIMIT + 1);
	localparam int LINK_W   = 7;
	localparam int FILL_W   = 13;
	localparam int LEN_W    = 16;
	localparam int OFF_W    = 16;
	localparam int ROOM_W   = 17;
	localparam int CMP_W    = 8;

	localparam logic [LINK_W-1:0] NO_LINK = {LINK_W{1'b1}};

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_TOO_LONG   = 3'd1,
		ST_EXHAUSTED  = 3'd2,
		ST_BAD_BLOCK  = 3'd3,
		ST_BAD_OFFSET = 3'd4,
		ST_OVER_FREE  = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_EXEC,
		S_MOVE,
		S_LINK
	} state_t;

	typedef struct packed {
		opcode_t           opcode;
		logic [LEN_W-1:0]  length;
		logic [BLK_W-1:0]  block_index;
		logic [OFF_W-1:0]  byte_offset;
	} req_t;

	typedef struct packed {
		logic              ok;
		status_t           status;
		logic [BLK_W-1:0]  granted_block;
		logic [FILL_W-1:0] granted_offset;
	} rsp_t;

	typedef struct packed {
		logic              we;
		logic [BLK_W-1:0]  waddr;
		logic [FILL_W-1:0] wdata;
		logic [BLK_W-1:0]  raddr;
	} fill_port_t;

	typedef struct packed {
		logic              we;
		logic [BLK_W-1:0]  waddr;
		logic [LINK_W-1:0] wdata;
		logic [BLK_W-1:0]  raddr;
	} link_port_t;

endpackage

// ===== sv/bba_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
module bba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/bba_ctrl.sv =====
// Request sequencer: reads, checks, updates and writes back the fill and link memories.
`include "block_bump_allocator_assert.svh"

module bba_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  bba_pkg::req_t               req,
	input  logic                        out_free,
	output logic                        result_valid,
	output bba_pkg::rsp_t               result,
	output bba_pkg::fill_port_t         fill_port,
	input  logic [bba_pkg::FILL_W-1:0]  fill_rd,
	output bba_pkg::link_port_t         link_port,
	input  logic [bba_pkg::LINK_W-1:0]  link_rd
);

	import bba_pkg::*;

	state_t            state_q, state_d;
	req_t              req_q, req_d;
	logic [BLK_W-1:0]  cur_q, cur_d;
	logic              present_q, present_d;
	logic [CNT_W-1:0]  created_q, created_d;
	logic              moved_q, moved_d;
	logic [LINK_W-1:0] saved_link_q, saved_link_d;

	logic [ROOM_W-1:0] fill_ext, len_ext, bb_ext;
	logic              too_long, no_room, link_ok, can_expand;
	logic              bad_block, bad_off, over_free;
	logic [FILL_W-1:0] fill_sum, fill_new;
	logic [BLK_W-1:0]  new_blk;

	assign fill_ext   = ROOM_W'(fill_rd);
	assign len_ext    = ROOM_W'(req_q.length);
	assign bb_ext     = ROOM_W'(BLOCK_BYTES);
	assign too_long   = len_ext > bb_ext;
	// Room check is guarded against unsigned wrap: an overfilled block never counts as short.
	assign no_room    = present_q && !moved_q && (fill_ext <= bb_ext) &&
		((bb_ext - fill_ext) < len_ext);
	assign link_ok    = (CMP_W'(link_rd) < CMP_W'(BLOCK_LIMIT)) &&
		(CMP_W'(link_rd) < CMP_W'(created_q));
	assign can_expand = CMP_W'(created_q) < CMP_W'(BLOCK_LIMIT);
	assign new_blk    = created_q[BLK_W-1:0];
	assign bad_block  = CMP_W'(req_q.block_index) >= CMP_W'(created_q);
	assign bad_off    = ROOM_W'(req_q.byte_offset) >= bb_ext;
	assign over_free  = fill_ext < len_ext;
	assign fill_sum   = fill_rd + FILL_W'(req_q.length);
	assign fill_new   = fill_rd - FILL_W'(req_q.length);

	assign req_stall  = (state_q != S_IDLE);

	always_comb begin
		state_d          = state_q;
		req_d            = req_q;
		cur_d            = cur_q;
		present_d        = present_q;
		created_d        = created_q;
		moved_d          = moved_q;
		saved_link_d     = saved_link_q;
		result_valid     = 1'b0;
		result           = '{ok: 1'b0, status: ST_OK, granted_block: '0, granted_offset: '0};
		fill_port.we     = 1'b0;
		fill_port.waddr  = '0;
		fill_port.wdata  = '0;
		link_port.we     = 1'b0;
		link_port.waddr  = '0;
		link_port.wdata  = NO_LINK;
		link_port.raddr  = cur_q;
		if (state_q == S_IDLE) begin
			fill_port.raddr = (req.opcode == OP_FREE) ? req.block_index : cur_q;
		end else begin
			fill_port.raddr = (req_q.opcode == OP_FREE) ? req_q.block_index : cur_q;
		end

		unique case (state_q)
			S_INIT: begin
				// Block zero exists from reset; the others are written when created.
				fill_port.we    = 1'b1;
				fill_port.waddr = '0;
				fill_port.wdata = '0;
				link_port.we    = 1'b1;
				link_port.waddr = '0;
				link_port.wdata = NO_LINK;
				state_d         = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					req_d   = req;
					moved_d = 1'b0;
					state_d = S_EXEC;
				end
			end
			S_MOVE: begin
				state_d = S_EXEC;
			end
			S_LINK: begin
				link_port.we    = 1'b1;
				link_port.waddr = req_q.block_index;
				link_port.wdata = saved_link_q;
				state_d         = S_IDLE;
			end
			S_EXEC: begin
				if (req_q.opcode == OP_ALLOC) begin
					if (too_long) begin
						if (out_free) begin
							result.status = ST_TOO_LONG;
							result_valid  = 1'b1;
							state_d       = S_IDLE;
						end
					end else if (no_room && link_ok) begin
						// Step to the recycled block; its fill level is read next cycle.
						cur_d   = link_rd[BLK_W-1:0];
						moved_d = 1'b1;
						state_d = S_MOVE;
					end else if (out_free) begin
						result_valid = 1'b1;
						state_d      = S_IDLE;
						if (!present_q || no_room) begin
							if (can_expand) begin
								fill_port.we          = 1'b1;
								fill_port.waddr       = new_blk;
								fill_port.wdata       = FILL_W'(req_q.length);
								link_port.we          = 1'b1;
								link_port.waddr       = new_blk;
								link_port.wdata       = NO_LINK;
								created_d             = created_q + CNT_W'(1);
								cur_d                 = new_blk;
								present_d             = 1'b1;
								result.granted_block  = new_blk;
							end else begin
								present_d     = 1'b0;
								result.status = ST_EXHAUSTED;
							end
						end else begin
							fill_port.we          = 1'b1;
							fill_port.waddr       = cur_q;
							fill_port.wdata       = fill_sum;
							result.granted_block  = cur_q;
							result.granted_offset = fill_rd;
						end
					end
				end else if (out_free) begin
					result_valid = 1'b1;
					state_d      = S_IDLE;
					if (bad_block) begin
						result.status = ST_BAD_BLOCK;
					end else if (bad_off) begin
						result.status = ST_BAD_OFFSET;
					end else if (over_free) begin
						result.status = ST_OVER_FREE;
					end else if (req_q.length != '0) begin
						fill_port.we    = 1'b1;
						fill_port.waddr = req_q.block_index;
						fill_port.wdata = fill_new;
						if (fill_new == '0) begin
							if (!present_q) begin
								cur_d           = req_q.block_index;
								present_d       = 1'b1;
								link_port.we    = 1'b1;
								link_port.waddr = req_q.block_index;
								link_port.wdata = NO_LINK;
							end else if (req_q.block_index != cur_q) begin
								// Splice in after the current block; the freed block's own
								// link takes the old successor in the following cycle.
								link_port.we    = 1'b1;
								link_port.waddr = cur_q;
								link_port.wdata = LINK_W'(req_q.block_index);
								saved_link_d    = link_rd;
								state_d         = S_LINK;
							end
						end
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		result.ok = (result.status == ST_OK);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_INIT;
			cur_q     <= '0;
			present_q <= 1'b1;
			created_q <= CNT_W'(1);
			moved_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			cur_q     <= cur_d;
			present_q <= present_d;
			created_q <= created_d;
			moved_q   <= moved_d;
		end
	end

	always_ff @(posedge clk) begin
		req_q        <= req_d;
		saved_link_q <= saved_link_d;
	end

	`BBA_ASSERT_SAME(a_cur_in_pool, present_q, CMP_W'(cur_q) < CMP_W'(created_q), "current block outside created pool")
	`BBA_ASSERT_NEXT(a_accept_exec, state_q == S_IDLE && req_valid, state_q == S_EXEC, "accepted request not executed")
	`BBA_ASSERT_NEXT(a_link_once, state_q == S_LINK, state_q == S_IDLE, "link splice took more than one cycle")
	`BBA_ASSERT_SAME(a_commit_slot, result_valid, state_q == S_EXEC && out_free, "result produced without a free output slot")

endmodule

// ===== sv/block_bump_allocator.sv =====
// Top level of the block bump allocator: memories, sequencer and result register.
//
//   Channel  Signals                       Direction  Content
//   req      req_valid, req_stall, req     in         opcode, length, block_index, byte_offset
//   rsp      rsp_valid, rsp_stall, rsp     out        ok, status, granted_block, granted_offset
//
// A request is taken in its transfer cycle, which issues the memory reads; the execute
// state then checks, updates and writes back. An allocate that steps to a recycled block
// passes through the move state, since the fill level of that block needs its own read
// and a second check; a free that splices a drained block behind the current one passes
// through the link state, for the second link-memory write.
// After reset the block writes the entries of block zero in its init state, with req_stall
// high; every other entry is written when its block is created.
// Results sit in an output register, so the next request is taken while one waits; the
// execute cycle holds while that register is full and rsp_stall is high.
module block_bump_allocator (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  bba_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output bba_pkg::rsp_t  rsp
);

	import bba_pkg::*;

	fill_port_t        fill_port;
	link_port_t        link_port;
	logic [FILL_W-1:0] fill_rd;
	logic [LINK_W-1:0] link_rd;
	logic              result_valid;
	rsp_t              result;
	logic              out_free;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	// The output register may be reloaded in the same cycle its result transfers.
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	bba_ram #(
		.WIDTH(FILL_W),
		.DEPTH(MAX_BLOCKS)
	) u_fill_ram (
		.clk  (clk),
		.we   (fill_port.we),
		.waddr(fill_port.waddr),
		.wdata(fill_port.wdata),
		.raddr(fill_port.raddr),
		.rdata(fill_rd)
	);

	bba_ram #(
		.WIDTH(LINK_W),
		.DEPTH(MAX_BLOCKS)
	) u_link_ram (
		.clk  (clk),
		.we   (link_port.we),
		.waddr(link_port.waddr),
		.wdata(link_port.wdata),
		.raddr(link_port.raddr),
		.rdata(link_rd)
	);

	bba_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.out_free    (out_free),
		.result_valid(result_valid),
		.result      (result),
		.fill_port   (fill_port),
		.fill_rd     (fill_rd),
		.link_port   (link_port),
		.link_rd     (link_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (result_valid) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result_valid) begin
			rsp_q <= result;
		end
	end

endmodule
